// File: design/lwk_pkg.sv
// Package for the longest-ones-with-k-flips block.
// Sizes, derived widths and the structs passed between the core and its cells.
// No dependencies.
package lwk_pkg;

    // sizing
    localparam int MAX_FLIPS = 64;
    localparam int POS_WIDTH = 16;
    localparam int CFG_W     = 7;
    localparam int OUT_W     = 16;

    // derived widths
    localparam int CNT_W = $clog2(MAX_FLIPS + 1);
    localparam int IDX_W = (MAX_FLIPS > 1) ? $clog2(MAX_FLIPS) : 1;
    localparam int K_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef logic [POS_WIDTH-1:0] t_pos;
    typedef logic [POS_WIDTH:0]   t_pos_ext;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [OUT_W-1:0]     t_len;

    // saturation limits
    localparam t_pos     POS_MAX = '1;
    localparam t_pos_ext LEN_MAX = (POS_WIDTH < OUT_W)
        ? t_pos_ext'((64'(1) << POS_WIDTH) - 64'(1))
        : t_pos_ext'((64'(1) << OUT_W) - 64'(1));

    // shared control for the row of zero-position cells
    typedef struct packed {
        logic pop;      // shift every entry one place towards the head
        t_pos new_pos;  // position written into the selected cell
    } t_cell_ctl;

    // window snapshot handed to the length stage
    typedef struct packed {
        t_pos     idx;
        t_pos_ext ws;
        logic     last;
    } t_win;

endpackage

// File: design/lwk_if.sv
// Channel interfaces: bit stream in, results out, configuration writes.
// Depends on lwk_pkg for field widths.
interface lwk_in_if;
    logic valid;
    logic ready;
    logic bit_value;
    logic is_last;

    modport source (output valid, output bit_value, output is_last, input ready);
    modport sink   (input valid, input bit_value, input is_last, output ready);
endinterface

interface lwk_out_if;
    logic                     valid;
    logic                     ready;
    logic [lwk_pkg::OUT_W-1:0] window_length;
    logic [lwk_pkg::OUT_W-1:0] best_length;
    logic                     final_result;

    modport source (output valid, output window_length, output best_length,
                    output final_result, input ready);
    modport sink   (input valid, input window_length, input best_length,
                    input final_result, output ready);
endinterface

interface lwk_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [lwk_pkg::CFG_W-1:0] max_flips;

    modport source (output valid, output max_flips, input ready);
    modport sink   (input valid, input max_flips, output ready);
endinterface

// File: design/lwk_cell.sv
// One cell of the zero-position FIFO: holds one stored position.
// Shifts from its neighbour on a pop, or loads the new position when selected.
// Depends on lwk_pkg.
module lwk_cell (
    input  logic               i_clk,
    input  lwk_pkg::t_cell_ctl i_ctl,
    input  logic               i_load,
    input  lwk_pkg::t_pos      i_next,
    output lwk_pkg::t_pos      o_pos
);

    lwk_pkg::t_pos r_pos;
    lwk_pkg::t_pos n_pos;

    // load wins over shift; otherwise hold
    always_comb begin
        n_pos = r_pos;
        if (i_load) begin
            n_pos = i_ctl.new_pos;
        end else if (i_ctl.pop) begin
            n_pos = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
    end

    assign o_pos = r_pos;

endmodule

// File: design/lwk_len_stage.sv
// Length stage: window length, running best and the output register.
// Depends on lwk_pkg.
module lwk_len_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s1_valid,
    input  lwk_pkg::t_win i_s1,
    input  logic          i_out_ready,
    output logic          o_take,
    output logic          o_valid,
    output lwk_pkg::t_len o_window_length,
    output lwk_pkg::t_len o_best_length,
    output logic          o_final_result
);

    logic              r_valid;
    lwk_pkg::t_len     r_best;
    lwk_pkg::t_len     r_win_len;
    lwk_pkg::t_len     r_best_len;
    logic              r_final;

    lwk_pkg::t_pos_ext end_pos;
    lwk_pkg::t_pos_ext raw_len;
    lwk_pkg::t_len     len;
    lwk_pkg::t_len     n_best;
    logic              load;

    // output register frees up when empty or being read
    assign o_take = !r_valid || i_out_ready;
    assign load   = o_take && i_s1_valid;

    // length = idx + 1 - start, floored at zero and saturated
    always_comb begin
        end_pos = {1'b0, i_s1.idx} + lwk_pkg::t_pos_ext'(1);
        raw_len = (end_pos >= i_s1.ws) ? (end_pos - i_s1.ws) : '0;
        if (raw_len > lwk_pkg::LEN_MAX) begin
            raw_len = lwk_pkg::LEN_MAX;
        end
        len    = raw_len[lwk_pkg::OUT_W-1:0];
        n_best = (len > r_best) ? len : r_best;
    end

    // control: valid flag and running best (cleared after the last request)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_best  <= '0;
        end else begin
            if (o_take) begin
                r_valid <= i_s1_valid;
            end
            if (load) begin
                r_best <= i_s1.last ? '0 : n_best;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_win_len  <= len;
            r_best_len <= n_best;
            r_final    <= i_s1.last;
        end
    end

    assign o_valid         = r_valid;
    assign o_window_length = r_win_len;
    assign o_best_length   = r_best_len;
    assign o_final_result  = r_final;

endmodule

// File: design/longest_ones_with_k_flips_core.sv
// Top level: longest run of ones allowing up to max_flips zeros (capped at MAX_FLIPS).
// Depends on lwk_pkg, lwk_if (interfaces), lwk_cell and lwk_len_stage.
//
//  channel   dir  handshake      payload
//  i_bit     in   valid/ready    bit_value, is_last
//  o_res     out  valid/ready    window_length, best_length, final_result
//  i_cfg     in   valid/ready    max_flips (always ready)
//
// One request accepted per clock unless the output stalls; it passes the stage register
// and output register. Window update and FIFO cells settle together, so a request can
// follow in the next cycle; the length subtract and best compare run in a second stage.
// A stalled output holds the result register, and ready falls back through both stages.
// Synchronous active-low reset clears the sequence state and sets max_flips to zero;
// FIFO cells are not cleared, only positions written in this sequence are read.
module longest_ones_with_k_flips_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lwk_in_if.sink    i_bit,
    lwk_out_if.source o_res,
    lwk_cfg_if.sink   i_cfg
);

    // configuration
    logic [lwk_pkg::CFG_W-1:0] r_max_flips;

    // sequence state
    lwk_pkg::t_pos     r_pos;
    lwk_pkg::t_pos     n_pos;
    lwk_pkg::t_pos_ext r_ws;
    lwk_pkg::t_pos_ext n_ws;
    lwk_pkg::t_cnt     r_cnt;
    lwk_pkg::t_cnt     n_cnt;

    // stage register between update and length stage
    logic              r_s1_valid;
    lwk_pkg::t_win     r_s1;

    logic              take;
    logic              s1_en;
    logic              in_fire;

    logic [lwk_pkg::K_W-1:0] k_cfg;
    logic [lwk_pkg::K_W-1:0] k_eff;
    logic [lwk_pkg::K_W-1:0] cnt_ext;

    lwk_pkg::t_cell_ctl      ctl;
    logic                    wr_en;
    lwk_pkg::t_idx           wr_idx;
    logic [lwk_pkg::MAX_FLIPS-1:0] load;
    lwk_pkg::t_pos           cell_pos [lwk_pkg::MAX_FLIPS];
    lwk_pkg::t_pos           cell_next [lwk_pkg::MAX_FLIPS];

    // configuration write port
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_flips <= '0;
        end else if (i_cfg.valid) begin
            r_max_flips <= i_cfg.max_flips;
        end
    end

    // handshake chain
    assign s1_en       = !r_s1_valid || take;
    assign i_bit.ready = s1_en;
    assign in_fire     = i_bit.valid && s1_en;

    // effective k = min(max_flips, MAX_FLIPS)
    always_comb begin
        k_cfg   = lwk_pkg::K_W'(r_max_flips);
        k_eff   = (k_cfg < lwk_pkg::K_W'(lwk_pkg::MAX_FLIPS))
                ? k_cfg : lwk_pkg::K_W'(lwk_pkg::MAX_FLIPS);
        cnt_ext = lwk_pkg::K_W'(r_cnt);
    end

    // window update for the incoming bit
    always_comb begin
        n_pos       = r_pos;
        n_ws        = r_ws;
        n_cnt       = r_cnt;
        ctl.pop     = 1'b0;
        ctl.new_pos = r_pos;
        wr_en       = 1'b0;
        wr_idx      = lwk_pkg::IDX_W'(r_cnt);
        if (in_fire) begin
            if (!i_bit.bit_value) begin
                if (k_eff == '0) begin
                    // no zeros allowed: window restarts past this element
                    n_ws  = {1'b0, r_pos} + lwk_pkg::t_pos_ext'(1);
                    n_cnt = '0;
                end else if (cnt_ext >= k_eff) begin
                    // drop the oldest zero, append the new one in its slot count
                    n_ws    = {1'b0, cell_pos[0]} + lwk_pkg::t_pos_ext'(1);
                    ctl.pop = 1'b1;
                    wr_en   = 1'b1;
                    wr_idx  = lwk_pkg::IDX_W'(r_cnt - lwk_pkg::t_cnt'(1));
                end else begin
                    wr_en = 1'b1;
                    n_cnt = r_cnt + lwk_pkg::t_cnt'(1);
                end
            end
            n_pos = (r_pos < lwk_pkg::POS_MAX) ? r_pos + lwk_pkg::t_pos'(1) : r_pos;
        end
    end

    // sequence state, cleared after the last element
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ws  <= '0;
            r_cnt <= '0;
        end else if (in_fire && i_bit.is_last) begin
            r_pos <= '0;
            r_ws  <= '0;
            r_cnt <= '0;
        end else begin
            r_pos <= n_pos;
            r_ws  <= n_ws;
            r_cnt <= n_cnt;
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_en) begin
            r_s1_valid <= i_bit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1.idx  <= r_pos;
            r_s1.ws   <= n_ws;
            r_s1.last <= i_bit.is_last;
        end
    end

    // row of zero-position cells, head at index 0
    genvar gi;
    generate
        for (gi = 0; gi < lwk_pkg::MAX_FLIPS; gi++) begin : g_cell
            assign load[gi] = wr_en && (wr_idx == lwk_pkg::IDX_W'(gi));
            if (gi == lwk_pkg::MAX_FLIPS - 1) begin : g_tail
                assign cell_next[gi] = ctl.new_pos;
            end else begin : g_mid
                assign cell_next[gi] = cell_pos[gi+1];
            end
            lwk_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (ctl),
                .i_load (load[gi]),
                .i_next (cell_next[gi]),
                .o_pos  (cell_pos[gi])
            );
        end
    endgenerate

    // length stage and output register
    lwk_len_stage u_len (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s1_valid      (r_s1_valid),
        .i_s1            (r_s1),
        .i_out_ready     (o_res.ready),
        .o_take          (take),
        .o_valid         (o_res.valid),
        .o_window_length (o_res.window_length),
        .o_best_length   (o_res.best_length),
        .o_final_result  (o_res.final_result)
    );

endmodule
